FILE: src/smix_pkg.sv
// shared constants, types and the gain table builder for the stem mixer
// no dependencies; imported by every module of the mixer
package smix_pkg;

  localparam int STEM_COUNT      = 4;
  localparam int SAMPLE_BITS     = 24;

  // per-stem setting register: gain field low, pan field high
  localparam int GAIN_FIELD_BITS = 11;
  localparam int PAN_FIELD_BITS  = 11;
  localparam int SETTING_BITS    = GAIN_FIELD_BITS + PAN_FIELD_BITS;
  localparam logic [SETTING_BITS-1:0] SETTING_RESET = SETTING_BITS'(2048600);

  // flags register: present, mute and solo masks then the mono bit
  localparam int FLAGS_BITS      = 3 * STEM_COUNT + 1;
  localparam int FLAG_MONO       = 3 * STEM_COUNT;
  localparam logic [FLAGS_BITS-1:0] FLAGS_RESET = FLAGS_BITS'((1 << STEM_COUNT) - 1);

  // configuration port
  localparam int CFG_FLAGS_IDX   = STEM_COUNT;
  localparam int CFG_IDX_BITS    = $clog2(STEM_COUNT + 1);
  localparam int CFG_DATA_BITS   = (FLAGS_BITS > SETTING_BITS) ? FLAGS_BITS : SETTING_BITS;

  // gain table, Q2.16, indexed by tenths of a dB above -60 dB
  localparam int GAIN_ENTRIES    = 721;
  localparam int GAIN_MAX_INDEX  = GAIN_ENTRIES - 1;
  localparam int GAIN_IDX_BITS   = $clog2(GAIN_ENTRIES);
  localparam int GAIN_Q_BITS     = 18;
  localparam logic [63:0] GAIN_START_Q60 = 64'd1152921504606847;
  localparam logic [63:0] GAIN_STEP_Q60  = 64'd1166271706426741886;

  // pan law, factors in Q1.10
  localparam int PAN_MAX_INDEX   = 2000;
  localparam int PAN_CENTRE      = 1000;
  localparam int PAN_MAG_BITS    = 10;
  localparam int UNITY_SHIFT     = 10;
  localparam int UNITY_Q10       = 1 << UNITY_SHIFT;
  localparam int FACTOR_BITS     = UNITY_SHIFT + 1;
  localparam int PAN_ROUND       = 500;
  localparam int PAN_NUM_BITS    = PAN_MAG_BITS + UNITY_SHIFT;
  // floor(x / 1000) == (x * ceil(2^30 / 1000)) >> 30 for every x below 2^20
  localparam int PAN_RECIP_SHIFT = 30;
  localparam int PAN_RECIP_BITS  = 21;
  localparam logic [PAN_RECIP_BITS-1:0] PAN_RECIP = PAN_RECIP_BITS'(1073742);
  localparam int SCALE_BITS      = GAIN_Q_BITS + FACTOR_BITS + 1;

  // mixing datapath
  localparam int PROD_BITS       = SAMPLE_BITS + GAIN_Q_BITS + 1;
  localparam int ACC_BITS        = PROD_BITS + $clog2(STEM_COUNT + 1);
  localparam int MIX_FRAC_BITS   = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic [GAIN_Q_BITS-1:0]        gain_rom_t [GAIN_ENTRIES];

  // item pipeline enables handed to each lane
  typedef struct packed {
    logic take;   // request accepted, capture samples
    logic shift;  // move samples to the multiply stage
    logic mult;   // form the weighted products
  } lane_ctrl_t;

  // 10^((u-600)/200) series in Q60, rounded to Q16; evaluated at elaboration
  function automatic gain_rom_t build_gain_table();
    gain_rom_t    tab;
    logic [63:0]  v;
    logic [127:0] prod;
    logic [63:0]  rnd;
    tab[0] = '0;
    v      = GAIN_START_Q60;
    for (int u = 1; u < GAIN_ENTRIES; u++) begin
      prod   = {64'd0, v} * {64'd0, GAIN_STEP_Q60};
      v      = prod[123:60];
      rnd    = v + (64'd1 << 43);
      tab[u] = rnd[44 +: GAIN_Q_BITS];
    end
    return tab;
  endfunction

endpackage

FILE: src/smix_lane.sv
// one mixer lane: gain rom, pan law and the weighted products of one stem
// depends on smix_pkg
module smix_lane (
  input  logic                                  clk_i,
  input  smix_pkg::lane_ctrl_t                  ctrl_i,
  input  logic [smix_pkg::SETTING_BITS-1:0]     setting_i,
  input  logic                                  mono_i,
  input  logic                                  audible_i,
  input  smix_pkg::sample_t                     left_i,
  input  smix_pkg::sample_t                     right_i,
  output smix_pkg::prod_t                       prod_l_o,
  output smix_pkg::prod_t                       prod_r_o
);
  import smix_pkg::*;

  localparam gain_rom_t GainRom = build_gain_table();

  logic [GAIN_FIELD_BITS-1:0]              gain_field;
  logic [PAN_FIELD_BITS-1:0]               pan_field;
  logic [GAIN_IDX_BITS-1:0]                gain_idx;
  logic [PAN_FIELD_BITS-1:0]               pan_clamped;
  logic [PAN_FIELD_BITS-1:0]               pan_diff;
  logic [PAN_MAG_BITS-1:0]                 span;
  logic [PAN_NUM_BITS-1:0]                 pan_num;
  logic [PAN_NUM_BITS+PAN_RECIP_BITS-1:0]  pan_prod;
  logic                                    pan_pos;
  logic                                    pan_neg;
  logic [FACTOR_BITS-1:0]                  side_d;
  logic [FACTOR_BITS-1:0]                  lf;
  logic [FACTOR_BITS-1:0]                  rf;
  logic [SCALE_BITS-1:0]                   gl_wide;
  logic [SCALE_BITS-1:0]                   gr_wide;

  logic [GAIN_Q_BITS-1:0]                  gain_q;
  logic [FACTOR_BITS-1:0]                  side_q;
  logic                                    pan_pos_q;
  logic                                    pan_neg_q;
  logic [GAIN_Q_BITS-1:0]                  gl_q;
  logic [GAIN_Q_BITS-1:0]                  gr_q;
  sample_t                                 l0_q, r0_q, l1_q, r1_q;
  prod_t                                   prod_l_q, prod_r_q;

  // clamp gain and pan fields
  assign gain_field  = setting_i[GAIN_FIELD_BITS-1:0];
  assign pan_field   = setting_i[SETTING_BITS-1 -: PAN_FIELD_BITS];
  assign gain_idx    = (gain_field > GAIN_FIELD_BITS'(GAIN_MAX_INDEX))
                     ? GAIN_IDX_BITS'(GAIN_MAX_INDEX) : gain_field[GAIN_IDX_BITS-1:0];
  assign pan_clamped = (pan_field > PAN_FIELD_BITS'(PAN_MAX_INDEX))
                     ? PAN_FIELD_BITS'(PAN_MAX_INDEX) : pan_field;
  assign pan_pos     = pan_clamped > PAN_FIELD_BITS'(PAN_CENTRE);
  assign pan_neg     = pan_clamped < PAN_FIELD_BITS'(PAN_CENTRE);
  assign pan_diff    = pan_pos ? pan_clamped - PAN_FIELD_BITS'(PAN_CENTRE)
                               : PAN_FIELD_BITS'(PAN_CENTRE) - pan_clamped;

  // side factor = ((1000 - |p|) * 1024 + 500) / 1000 via reciprocal
  assign span      = PAN_MAG_BITS'(PAN_CENTRE) - pan_diff[PAN_MAG_BITS-1:0];
  assign pan_num   = {span, {UNITY_SHIFT{1'b0}}} + PAN_NUM_BITS'(PAN_ROUND);
  assign pan_prod  = (PAN_NUM_BITS+PAN_RECIP_BITS)'(pan_num)
                   * (PAN_NUM_BITS+PAN_RECIP_BITS)'(PAN_RECIP);
  assign side_d    = pan_prod[PAN_RECIP_SHIFT +: FACTOR_BITS];

  // per-side stem gain in Q2.16
  assign lf      = (pan_pos_q && !mono_i) ? side_q : FACTOR_BITS'(UNITY_Q10);
  assign rf      = pan_neg_q ? side_q : FACTOR_BITS'(UNITY_Q10);
  assign gl_wide = SCALE_BITS'(gain_q) * SCALE_BITS'(lf) + SCALE_BITS'(UNITY_Q10 / 2);
  assign gr_wide = SCALE_BITS'(gain_q) * SCALE_BITS'(rf) + SCALE_BITS'(UNITY_Q10 / 2);

  // settings path, follows the registers every cycle
  always_ff @(posedge clk_i) begin
    gain_q    <= GainRom[gain_idx];
    side_q    <= side_d;
    pan_pos_q <= pan_pos;
    pan_neg_q <= pan_neg;
    gl_q      <= gl_wide[UNITY_SHIFT +: GAIN_Q_BITS];
    gr_q      <= gr_wide[UNITY_SHIFT +: GAIN_Q_BITS];
  end

  // sample path
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take) begin
      l0_q <= left_i;
      r0_q <= right_i;
    end
    if (ctrl_i.shift) begin
      l1_q <= l0_q;
      r1_q <= r0_q;
    end
    if (ctrl_i.mult) begin
      if (audible_i) begin
        prod_l_q <= prod_t'(l1_q) * prod_t'($signed({1'b0, gl_q}));
        prod_r_q <= prod_t'(r1_q) * prod_t'($signed({1'b0, gr_q}));
      end else begin
        prod_l_q <= '0;
        prod_r_q <= '0;
      end
    end
  end

  assign prod_l_o = prod_l_q;
  assign prod_r_o = prod_r_q;

endmodule

FILE: src/smix_merge.sv
// merging stage: sums lane products, rounds, saturates and drives the result
// depends on smix_pkg
module smix_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic                mono_i,
  input  smix_pkg::prod_t     prod_l_i [smix_pkg::STEM_COUNT],
  input  smix_pkg::prod_t     prod_r_i [smix_pkg::STEM_COUNT],
  output logic                done_o,
  output smix_pkg::sample_t   mix_left_o,
  output smix_pkg::sample_t   mix_right_o,
  output logic                clipped_o
);
  import smix_pkg::*;

  typedef logic signed [ACC_BITS-1:0] acc_t;
  typedef logic signed [ACC_BITS:0]   rnd_t;

  localparam rnd_t SatHi = rnd_t'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
  localparam rnd_t SatLo = -SatHi - rnd_t'(1);
  localparam rnd_t RoundHalf = rnd_t'(1) <<< (MIX_FRAC_BITS - 1);

  acc_t    sum_l_d, sum_r_d;
  acc_t    sum_l_q, sum_r_q;
  logic    sum_valid_q;
  rnd_t    rnd_l, rnd_r;
  sample_t sat_l, sat_r;
  logic    clip_l, clip_r;
  logic    done_q;
  sample_t mix_left_q, mix_right_q;
  logic    clipped_q;

  always_comb begin
    sum_l_d = '0;
    sum_r_d = '0;
    for (int i = 0; i < STEM_COUNT; i++) begin
      sum_l_d = sum_l_d + acc_t'(prod_l_i[i]);
      sum_r_d = sum_r_d + acc_t'(prod_r_i[i]);
    end
  end

  // round half up then saturate to the sample width
  always_comb begin
    rnd_l  = (rnd_t'(sum_l_q) + RoundHalf) >>> MIX_FRAC_BITS;
    rnd_r  = (rnd_t'(sum_r_q) + RoundHalf) >>> MIX_FRAC_BITS;
    clip_l = (rnd_l > SatHi) || (rnd_l < SatLo);
    clip_r = (rnd_r > SatHi) || (rnd_r < SatLo);
    if (rnd_l > SatHi) begin
      sat_l = sample_t'(SatHi);
    end else if (rnd_l < SatLo) begin
      sat_l = sample_t'(SatLo);
    end else begin
      sat_l = sample_t'(rnd_l);
    end
    if (rnd_r > SatHi) begin
      sat_r = sample_t'(SatHi);
    end else if (rnd_r < SatLo) begin
      sat_r = sample_t'(SatLo);
    end else begin
      sat_r = sample_t'(rnd_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      sum_valid_q <= valid_i;
      done_q      <= sum_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      sum_l_q <= sum_l_d;
      sum_r_q <= sum_r_d;
    end
    if (sum_valid_q) begin
      mix_left_q  <= sat_l;
      mix_right_q <= mono_i ? '0 : sat_r;
      clipped_q   <= clip_l | (!mono_i & clip_r);
    end
  end

  assign done_o      = done_q;
  assign mix_left_o  = mix_left_q;
  assign mix_right_o = mix_right_q;
  assign clipped_o   = clipped_q;

endmodule

FILE: src/stem_mixer_mute_solo_pan.sv
// top level of the four-stem mixer: settings registers, stem lanes, merge
// depends on smix_pkg, smix_lane and smix_merge
//
// usage
//   request channel: a stereo frame of all four stems is taken at each rising
//   edge with start high and busy low; busy never rises, so one frame per
//   cycle is taken indefinitely
//   result channel: done_o is high for exactly one cycle with mix_left_o,
//   mix_right_o and clipped_o; the receiver cannot stall, so nothing is held
//   pipeline: done_o rises after the capture, align, multiply, lane sum and
//   round-and-saturate registers behind the accepting edge; throughput is
//   one frame per cycle, set by the per-lane product stage and the adder tree
//   settings port: cfg_ready_o is always high; index 0..3 writes a stem's gain
//   and pan, index 4 the present, mute, solo and mono flags; other indexes
//   are dropped; write only while no frame is in flight
//   reset: all stems at 0 dB and centre, all present, none muted or soloed,
//   stereo output; no frame in flight and done_o low
module stem_mixer_mute_solo_pan (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // request
  input  logic                                  start,
  output logic                                  busy,
  input  smix_pkg::sample_t                     s0_left_i,
  input  smix_pkg::sample_t                     s0_right_i,
  input  smix_pkg::sample_t                     s1_left_i,
  input  smix_pkg::sample_t                     s1_right_i,
  input  smix_pkg::sample_t                     s2_left_i,
  input  smix_pkg::sample_t                     s2_right_i,
  input  smix_pkg::sample_t                     s3_left_i,
  input  smix_pkg::sample_t                     s3_right_i,
  // result
  output logic                                  done_o,
  output smix_pkg::sample_t                     mix_left_o,
  output smix_pkg::sample_t                     mix_right_o,
  output logic                                  clipped_o,
  // settings writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [smix_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [smix_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);
  import smix_pkg::*;

  logic [SETTING_BITS-1:0] setting_q [STEM_COUNT];
  logic [FLAGS_BITS-1:0]   flags_q;
  logic                    cfg_we;

  logic [STEM_COUNT-1:0]   present, mute, solo, audible;
  logic                    any_solo;
  logic                    mono;

  logic                    accept;
  logic                    v0_q, v1_q, v2_q;
  lane_ctrl_t              lane_ctrl;

  sample_t                 left_in  [STEM_COUNT];
  sample_t                 right_in [STEM_COUNT];
  prod_t                   prod_l   [STEM_COUNT];
  prod_t                   prod_r   [STEM_COUNT];

  // frames flow through without back-pressure
  assign busy        = 1'b0;
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // settings registers; writes beyond the flags index fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STEM_COUNT; i++) begin
        setting_q[i] <= SETTING_RESET;
      end
      flags_q <= FLAGS_RESET;
    end else if (cfg_we) begin
      for (int i = 0; i < STEM_COUNT; i++) begin
        if (cfg_index_i == CFG_IDX_BITS'(i)) begin
          setting_q[i] <= cfg_data_i[SETTING_BITS-1:0];
        end
      end
      if (cfg_index_i == CFG_IDX_BITS'(CFG_FLAGS_IDX)) begin
        flags_q <= cfg_data_i[FLAGS_BITS-1:0];
      end
    end
  end

  // mute and solo: a solo on an absent stem does not count
  assign present  = flags_q[0 +: STEM_COUNT];
  assign mute     = flags_q[STEM_COUNT +: STEM_COUNT];
  assign solo     = flags_q[2*STEM_COUNT +: STEM_COUNT];
  assign mono     = flags_q[FLAG_MONO];
  assign any_solo = |(solo & present);
  assign audible  = present & ~mute & (solo | {STEM_COUNT{~any_solo}});

  // frame pipeline occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  assign lane_ctrl.take  = accept;
  assign lane_ctrl.shift = v0_q;
  assign lane_ctrl.mult  = v1_q;

  // map the stem ports onto lane order
  assign left_in[0]  = s0_left_i;
  assign right_in[0] = s0_right_i;
  assign left_in[1]  = s1_left_i;
  assign right_in[1] = s1_right_i;
  assign left_in[2]  = s2_left_i;
  assign right_in[2] = s2_right_i;
  assign left_in[3]  = s3_left_i;
  assign right_in[3] = s3_right_i;

  for (genvar g = 0; g < STEM_COUNT; g++) begin : g_lane
    smix_lane u_lane (
      .clk_i     (clk_i),
      .ctrl_i    (lane_ctrl),
      .setting_i (setting_q[g]),
      .mono_i    (mono),
      .audible_i (audible[g]),
      .left_i    (left_in[g]),
      .right_i   (right_in[g]),
      .prod_l_o  (prod_l[g]),
      .prod_r_o  (prod_r[g])
    );
  end

  smix_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v2_q),
    .mono_i      (mono),
    .prod_l_i    (prod_l),
    .prod_r_i    (prod_r),
    .done_o      (done_o),
    .mix_left_o  (mix_left_o),
    .mix_right_o (mix_right_o),
    .clipped_o   (clipped_o)
  );

endmodule

FILE: sim/stem_mixer_mute_solo_pan_tb.sv
// self-checking testbench for the four-stem mixer with mute, solo and linear pan
// depends on smix_pkg and stem_mixer_mute_solo_pan; predicts every mixed frame
// in-line and checks it field by field against the result strobe
module stem_mixer_mute_solo_pan_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import smix_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_FRAMES = 480;
  localparam int SAMPLE_MAX    = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN    = -(1 << (SAMPLE_BITS - 1));
  localparam int FIELD_TOP     = (1 << GAIN_FIELD_BITS) - 1;
  localparam int STEM_IDX_BITS = $clog2(STEM_COUNT);

  // one stereo frame per stem, as offered on the request ports
  typedef struct {
    sample_t l [STEM_COUNT];
    sample_t r [STEM_COUNT];
  } frame_t;

  // one mixed output frame
  typedef struct {
    sample_t left;
    sample_t right;
    logic    clip;
  } mix_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  sample_t                  s0_left_i, s0_right_i, s1_left_i, s1_right_i;
  sample_t                  s2_left_i, s2_right_i, s3_left_i, s3_right_i;
  logic                     done_o;
  sample_t                  mix_left_o;
  sample_t                  mix_right_o;
  logic                     clipped_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  // mirror of the settings registers and the dB-to-linear curve
  logic [SETTING_BITS-1:0]  stem_cfg [STEM_COUNT];
  logic [FLAGS_BITS-1:0]    route_flags;
  int unsigned              db_to_q16 [GAIN_ENTRIES];

  // predicted mixes still owed by the block, oldest first
  mix_t                     pending_mix_q [$];
  mix_t                     mix_due;

  bit                       gaps_on;
  int                       cycle_count;
  int                       mismatches;
  int                       frames_sent;
  int                       mixes_checked;
  int                       clips_seen;
  int                       reg_writes;

  always #4 clk_i = ~clk_i;

  stem_mixer_mute_solo_pan i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .s0_left_i   (s0_left_i),
    .s0_right_i  (s0_right_i),
    .s1_left_i   (s1_left_i),
    .s1_right_i  (s1_right_i),
    .s2_left_i   (s2_left_i),
    .s2_right_i  (s2_right_i),
    .s3_left_i   (s3_left_i),
    .s3_right_i  (s3_right_i),
    .done_o      (done_o),
    .mix_left_o  (mix_left_o),
    .mix_right_o (mix_right_o),
    .clipped_o   (clipped_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 10^((u-600)/200) curve: Q60 geometric series, each entry rounded to Q16
  initial begin : gain_curve
    logic [127:0] wide;
    logic [63:0]  level;
    db_to_q16[0] = 0;
    level        = GAIN_START_Q60;
    for (int u = 1; u < GAIN_ENTRIES; u++) begin
      wide         = 128'(level) * 128'(GAIN_STEP_Q60);
      level        = wide[123:60];
      db_to_q16[u] = 32'((level + (64'd1 << 43)) >> 44);
    end
  end

  // round half up out of Q16, then clamp to the sample range
  function automatic sample_t round_clamp(input longint acc, inout logic clip);
    longint r;
    r = (acc + 64'sd32768) >>> 16;
    if (r > SAMPLE_MAX) begin
      clip = 1'b1;
      return sample_t'(SAMPLE_MAX);
    end
    if (r < SAMPLE_MIN) begin
      clip = 1'b1;
      return sample_t'(SAMPLE_MIN);
    end
    return sample_t'(r);
  endfunction

  // expected output frame for the current register mirror
  function automatic mix_t mix_frame(input frame_t f);
    logic [STEM_COUNT-1:0] present, mute, solo;
    logic                  mono, any_solo;
    int unsigned           gidx, pidx;
    longint                p, mag, side, lf, rf, gl, gr, acc_l, acc_r;
    mix_t                  m;
    present  = route_flags[STEM_COUNT-1:0];
    mute     = route_flags[2*STEM_COUNT-1:STEM_COUNT];
    solo     = route_flags[3*STEM_COUNT-1:2*STEM_COUNT];
    mono     = route_flags[FLAG_MONO];
    // a solo bit on a stem that is not present does not count
    any_solo = |(solo & present);
    acc_l    = 0;
    acc_r    = 0;
    for (int s = 0; s < STEM_COUNT; s++) begin
      if (present[s] && !mute[s] && (!any_solo || solo[s])) begin
        gidx = 32'(stem_cfg[s][GAIN_FIELD_BITS-1:0]);
        if (gidx > GAIN_MAX_INDEX) gidx = GAIN_MAX_INDEX;
        pidx = 32'(stem_cfg[s][SETTING_BITS-1:GAIN_FIELD_BITS]);
        if (pidx > PAN_MAX_INDEX) pidx = PAN_MAX_INDEX;
        p     = longint'(pidx) - PAN_CENTRE;
        mag   = (p < 0) ? -p : p;
        side  = ((PAN_CENTRE - mag) * UNITY_Q10 + PAN_ROUND) / 1000;
        // mono keeps the left side at plain gain whatever the pan
        lf    = (p > 0 && !mono) ? side : UNITY_Q10;
        rf    = (p < 0) ? side : UNITY_Q10;
        gl    = (longint'(db_to_q16[gidx]) * lf + 512) >> UNITY_SHIFT;
        gr    = (longint'(db_to_q16[gidx]) * rf + 512) >> UNITY_SHIFT;
        acc_l += longint'(f.l[s]) * gl;
        acc_r += longint'(f.r[s]) * gr;
      end
    end
    m.clip = 1'b0;
    m.left = round_clamp(acc_l, m.clip);
    if (mono) m.right = '0;
    else      m.right = round_clamp(acc_r, m.clip);
    return m;
  endfunction

  function automatic logic [SETTING_BITS-1:0] pack_setting(
    input logic [GAIN_FIELD_BITS-1:0] gain,
    input logic [PAN_FIELD_BITS-1:0]  pan
  );
    return {pan, gain};
  endfunction

  function automatic logic [FLAGS_BITS-1:0] pack_flags(
    input logic [STEM_COUNT-1:0] present,
    input logic [STEM_COUNT-1:0] mute,
    input logic [STEM_COUNT-1:0] solo,
    input logic                  mono
  );
    return {mono, solo, mute, present};
  endfunction

  // extremes, near-silence and full-range noise
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(SAMPLE_MAX);
      1:       return sample_t'(SAMPLE_MIN);
      2:       return sample_t'($urandom_range(0, 1) ? 0 : -1);
      3, 4:    return sample_t'(int'($urandom_range(0, 8191)) - 4096);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic frame_t frame_rand();
    frame_t f;
    for (int s = 0; s < STEM_COUNT; s++) begin
      f.l[s] = rand_sample();
      f.r[s] = rand_sample();
    end
    return f;
  endfunction

  function automatic frame_t frame_flat(input sample_t l, input sample_t r);
    frame_t f;
    for (int s = 0; s < STEM_COUNT; s++) begin
      f.l[s] = l;
      f.r[s] = r;
    end
    return f;
  endfunction

  // offer one frame; start stays high after acceptance so back-to-back
  // frames go in with no bubble
  task automatic send_frame(input frame_t f);
    int gap;
    gap = 0;
    if (gaps_on) begin
      case ($urandom_range(0, 19))
        0:             gap = $urandom_range(8, 40);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default:       gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    s0_left_i  <= f.l[0];
    s0_right_i <= f.r[0];
    s1_left_i  <= f.l[1];
    s1_right_i <= f.r[1];
    s2_left_i  <= f.l[2];
    s2_right_i <= f.r[2];
    s3_left_i  <= f.l[3];
    s3_right_i <= f.r[3];
    do @(posedge clk_i); while (busy);
    pending_mix_q = {pending_mix_q, mix_frame(f)};
    frames_sent++;
  endtask

  // stop requests and wait until every owed mix has come out
  task automatic drain();
    start <= 1'b0;
    while (pending_mix_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // settings write, only with the pipeline empty; unknown indexes are dropped
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < CFG_FLAGS_IDX)
      stem_cfg[idx[STEM_IDX_BITS-1:0]] = data[SETTING_BITS-1:0];
    else if (idx == CFG_FLAGS_IDX)
      route_flags = data[FLAGS_BITS-1:0];
    reg_writes++;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // reset settings: every stem at 0 dB and centre, all present, stereo
  task automatic test_power_on_defaults();
    gaps_on = 1'b0;
    send_frame(frame_flat('0, '0));
    send_frame(frame_flat(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX)));
    send_frame(frame_flat(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN)));
    send_frame(frame_rand());
  endtask

  // silence at -60 dB, +12 dB, clamped gain and pan fields, hard left/right
  task automatic test_gain_pan_limits();
    write_reg(0, pack_setting(0, 0));
    write_reg(1, pack_setting(GAIN_FIELD_BITS'(GAIN_MAX_INDEX),
                              PAN_FIELD_BITS'(PAN_MAX_INDEX)));
    write_reg(2, pack_setting(GAIN_FIELD_BITS'(FIELD_TOP), PAN_FIELD_BITS'(FIELD_TOP)));
    write_reg(3, pack_setting(1, 1));
    send_frame(frame_flat(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX)));
    send_frame(frame_flat(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN)));
    send_frame(frame_rand());
    send_frame(frame_rand());
    // just off centre both ways, gain one step past the top
    write_reg(0, pack_setting(GAIN_FIELD_BITS'(GAIN_MAX_INDEX + 1),
                              PAN_FIELD_BITS'(PAN_CENTRE - 1)));
    write_reg(1, pack_setting(GAIN_FIELD_BITS'(GAIN_MAX_INDEX - 120),
                              PAN_FIELD_BITS'(PAN_CENTRE + 1)));
    send_frame(frame_flat(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN)));
    send_frame(frame_rand());
  endtask

  // present, mute, solo and mono combinations
  task automatic test_routing_flags();
    logic [CFG_DATA_BITS-1:0] wide_flags;
    // nothing present, then everything muted: both give silence
    write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), pack_flags(4'b0000, 4'b0000, 4'b0000, 1'b0));
    send_frame(frame_flat(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX)));
    write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), pack_flags(4'b1111, 4'b1111, 4'b0000, 1'b0));
    send_frame(frame_flat(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX)));
    // solo on an absent stem must not silence the others
    write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), pack_flags(4'b0111, 4'b0000, 4'b1000, 1'b0));
    send_frame(frame_rand());
    // two stems soloed, one of them also muted
    write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), pack_flags(4'b1111, 4'b0100, 4'b0110, 1'b0));
    send_frame(frame_rand());
    // mono: left pans ignored, right forced to zero, clip from left only
    write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), pack_flags(4'b1111, 4'b0000, 4'b0000, 1'b1));
    send_frame(frame_flat(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX)));
    send_frame(frame_flat('0, sample_t'(SAMPLE_MIN)));
    send_frame(frame_rand());
    // spare data bits above the flags are dropped
    wide_flags = '1;
    wide_flags[FLAGS_BITS-1:0] = pack_flags(4'b1011, 4'b0001, 4'b0000, 1'b0);
    write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), wide_flags);
    send_frame(frame_rand());
  endtask

  // writes to indexes past the flags register change nothing
  task automatic test_unused_indexes();
    for (int k = CFG_FLAGS_IDX + 1; k < (1 << CFG_IDX_BITS); k++)
      write_reg(CFG_IDX_BITS'(k), CFG_DATA_BITS'($urandom));
    send_frame(frame_rand());
    send_frame(frame_flat(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN)));
  endtask

  // phases of random settings, each followed by a burst of random frames
  task automatic test_random_mixing();
    int                       phase_len;
    int                       done_frames;
    logic [GAIN_FIELD_BITS-1:0] gain;
    logic [PAN_FIELD_BITS-1:0]  pan;
    logic [STEM_COUNT-1:0]    present, mute, solo;
    logic [CFG_DATA_BITS-1:0] flag_word;
    done_frames = 0;
    while (done_frames < RANDOM_FRAMES) begin
      for (int s = 0; s < STEM_COUNT; s++) begin
        case ($urandom_range(0, 9))
          0:       gain = '0;
          1:       gain = GAIN_FIELD_BITS'(GAIN_MAX_INDEX);
          2:       gain = GAIN_FIELD_BITS'($urandom_range(GAIN_MAX_INDEX + 1, FIELD_TOP));
          default: gain = GAIN_FIELD_BITS'($urandom_range(0, GAIN_MAX_INDEX));
        endcase
        case ($urandom_range(0, 9))
          0:       pan = '0;
          1:       pan = PAN_FIELD_BITS'(PAN_MAX_INDEX);
          2:       pan = PAN_FIELD_BITS'($urandom_range(PAN_MAX_INDEX + 1, FIELD_TOP));
          3:       pan = PAN_FIELD_BITS'(PAN_CENTRE);
          default: pan = PAN_FIELD_BITS'($urandom_range(0, PAN_MAX_INDEX));
        endcase
        write_reg(CFG_IDX_BITS'(s), pack_setting(gain, pan));
      end
      // mostly every stem present and little muting, so mixes stay busy
      present   = $urandom_range(0, 1) ? '1 : STEM_COUNT'($urandom);
      mute      = ($urandom_range(0, 9) < 6) ? '0 : STEM_COUNT'($urandom);
      solo      = ($urandom_range(0, 9) < 6) ? '0 : STEM_COUNT'($urandom);
      flag_word = CFG_DATA_BITS'($urandom);
      flag_word[FLAGS_BITS-1:0] = pack_flags(present, mute, solo,
                                             1'($urandom_range(0, 1)));
      write_reg(CFG_IDX_BITS'(CFG_FLAGS_IDX), flag_word);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_BITS'($urandom_range(CFG_FLAGS_IDX + 1, (1 << CFG_IDX_BITS) - 1)),
                  CFG_DATA_BITS'($urandom));
      // some phases run flat out with no gaps at all
      gaps_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(30, 60);
      repeat (phase_len) send_frame(frame_rand());
      done_frames += phase_len;
    end
  endtask

  // every strobed result is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_mix_q.size() == 0) begin
        $display("%0t ns: mix result with nothing expected, got left %0d right %0d clip %0b",
                 $realtime, mix_left_o, mix_right_o, clipped_o);
        mismatches++;
      end else begin
        mix_due = pending_mix_q.pop_front();
        mixes_checked++;
        if (clipped_o === 1'b1) clips_seen++;
        if (mix_left_o !== mix_due.left) begin
          $display("%0t ns: mix_left expected %0d got %0d",
                   $realtime, mix_due.left, mix_left_o);
          mismatches++;
        end
        if (mix_right_o !== mix_due.right) begin
          $display("%0t ns: mix_right expected %0d got %0d",
                   $realtime, mix_due.right, mix_right_o);
          mismatches++;
        end
        if (clipped_o !== mix_due.clip) begin
          $display("%0t ns: clipped expected %0b got %0b",
                   $realtime, mix_due.clip, clipped_o);
          mismatches++;
        end
      end
    end
  end

  // watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: run stopped after %0d cycles with %0d mixes outstanding",
               $realtime, cycle_count, pending_mix_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    s0_left_i   <= '0;
    s0_right_i  <= '0;
    s1_left_i   <= '0;
    s1_right_i  <= '0;
    s2_left_i   <= '0;
    s2_right_i  <= '0;
    s3_left_i   <= '0;
    s3_right_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    for (int s = 0; s < STEM_COUNT; s++) stem_cfg[s] = SETTING_RESET;
    route_flags = FLAGS_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_defaults();
    test_gain_pan_limits();
    test_routing_flags();
    test_unused_indexes();
    test_random_mixing();

    // let the last frames fall out of the five-stage pipe
    drain();
    repeat (8) @(posedge clk_i);

    $display("covered %0d frames across %0d settings writes, including mono, solo and clamps",
             frames_sent, reg_writes);
    $display("checked %0d mixes, %0d of them saturated", mixes_checked, clips_seen);
    if (mismatches == 0 && pending_mix_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
